>>> rtl/core/inode_group_allocator_defines.svh
// ----------------------------------------------------------------------------
// Inode group allocator assertion macros
// Concurrent assertion wrappers clocked on i_clk, gated by reset or not.
// ----------------------------------------------------------------------------
`ifndef INODE_GROUP_ALLOCATOR_DEFINES_SVH
`define INODE_GROUP_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define IGA_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define IGA_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define IGA_ASSERT(name, prop, msg)
`define IGA_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

>>> rtl/core/iga_pkg.sv
// ----------------------------------------------------------------------------
// iga_pkg
// Shared constants, codes and types of the inode group allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package iga_pkg;

    localparam int MAX_GROUPS = 16;
    localparam int MAX_IPG    = 1024;

    localparam int GRP_W      = $clog2(MAX_GROUPS);
    localparam int CNT_W      = 11;
    localparam int NG_W       = 5;
    localparam int TOT_W      = 15;
    localparam int FB_W       = 16;
    localparam int INO_W      = 15;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 11;

    localparam int WORD_W     = 32;
    localparam int BIT_W      = $clog2(WORD_W);
    localparam int WPG        = MAX_IPG / WORD_W;
    localparam int WIDX_W     = $clog2(WPG);
    localparam int IDX_W      = WIDX_W + BIT_W;
    localparam int BM_DEPTH   = MAX_GROUPS * WPG;
    localparam int BM_AW      = $clog2(BM_DEPTH);

    localparam int DIV_W      = 15;
    localparam int DVS_W      = 11;
    localparam int DCNT_W     = $clog2(DIV_W);

    localparam logic [CNT_W-1:0] RST_IPG   = CNT_W'(MAX_IPG);
    localparam logic [NG_W-1:0]  RST_NG    = NG_W'(MAX_GROUPS);
    localparam logic [CNT_W-1:0] RST_LAST  = CNT_W'(MAX_IPG);
    localparam logic [TOT_W-1:0] RST_TOTAL = TOT_W'(MAX_GROUPS * MAX_IPG);
    localparam logic [CNT_W-1:0] MIN_IPG   = CNT_W'(8);

    localparam logic [CFG_IDX_W-1:0] CFG_IPG  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_NG   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_LAST = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_ITZ  = CFG_IDX_W'(3);

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_SET_FB = 2'd2,
        OP_REINIT = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_GRP,
        S_RD,
        S_CHK,
        S_FREE_RD,
        S_FREE_WR,
        S_FIN
    } t_state;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
        logic [DVS_W-1:0] rem;
    } t_div_rsp;

endpackage

>>> rtl/core/iga_ram.sv
// ----------------------------------------------------------------------------
// iga_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iga_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/iga_div.sv
// ----------------------------------------------------------------------------
// iga_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "inode_group_allocator_defines.svh"

module iga_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  iga_pkg::t_div_req i_req,
    output iga_pkg::t_div_rsp o_rsp
);

    import iga_pkg::*;

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [DCNT_W-1:0] r_cnt, n_cnt;
    logic [DIV_W-1:0]  r_q, n_q;
    logic [DVS_W-1:0]  r_r, n_r;
    logic [DVS_W-1:0]  r_d, n_d;

    logic [DVS_W:0]    shifted;
    logic [DVS_W:0]    diff;

    always_comb begin
        shifted = {r_r, r_q[DIV_W-1]};
        diff    = shifted - {1'b0, r_d};
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_q     = r_q;
        n_r     = r_r;
        n_d     = r_d;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_q    = i_req.dividend;
            n_r    = '0;
            n_d    = i_req.divisor;
        end else if (r_busy) begin
            n_q   = {r_q[DIV_W-2:0], ~diff[DVS_W]};
            n_r   = diff[DVS_W] ? shifted[DVS_W-1:0] : diff[DVS_W-1:0];
            n_cnt = r_cnt + DCNT_W'(1);
            if (r_cnt == DCNT_W'(DIV_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q <= n_q;
        r_r <= n_r;
        r_d <= n_d;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
    assign o_rsp.rem  = r_r;

    `IGA_ASSERT(a_div_cnt_range, r_busy |-> r_cnt <= DCNT_W'(DIV_W - 1), "divider step count overrun")
    `IGA_ASSERT(a_div_done_idle, r_done |-> !r_busy, "divider done while still busy")

endmodule

>>> rtl/core/inode_group_allocator.sv
// ----------------------------------------------------------------------------
// inode_group_allocator
// Per-group inode bitmap allocator with free, directory and unused counters.
// ----------------------------------------------------------------------------
// After reset the bitmap RAM is cleared one 32-bit word per cycle, all 512
// words, during which no item is accepted (configuration writes are taken).
// One item is worked at a time. Allocate waits on the shared divider for the
// average free count, then examines the groups in order (S_GRP) and reads
// bitmap words through the registered RAM read (S_RD, then S_CHK). Free
// waits on the same divider to split the inode number, then does a
// read-modify-write (S_FREE_RD, S_FREE_WR). Set free blocks and reinitialize
// go straight to S_FIN. The result sits in an output register, so the next
// item may be accepted while it waits.
`timescale 1ns / 1ps
`include "inode_group_allocator_defines.svh"

module inode_group_allocator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [iga_pkg::OP_W-1:0]        i_op,
    input  logic                            i_is_dir,
    input  logic [iga_pkg::INO_W-1:0]       i_inode_number,
    input  logic [iga_pkg::GRP_W-1:0]       i_group_sel,
    input  logic [iga_pkg::FB_W-1:0]        i_free_blocks,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_status,
    output logic [iga_pkg::INO_W-1:0]       o_allocated_inode,
    output logic [iga_pkg::GRP_W-1:0]       o_alloc_group,
    output logic [iga_pkg::TOT_W-1:0]       o_total_free,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [iga_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [iga_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    import iga_pkg::*;

    function automatic logic [CNT_W-1:0] gsize(input logic [GRP_W-1:0] g,
                                               input logic [NG_W-1:0]  n,
                                               input logic [CNT_W-1:0] ipg,
                                               input logic [CNT_W-1:0] last);
        logic is_last;
        is_last = (NG_W'(g) + NG_W'(1)) == n;
        return is_last ? last : ipg;
    endfunction

    // configuration
    logic [CNT_W-1:0] r_ipg;
    logic [NG_W-1:0]  r_ng;
    logic [CNT_W-1:0] r_last;
    logic             r_itz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ipg  <= RST_IPG;
            r_ng   <= RST_NG;
            r_last <= RST_LAST;
            r_itz  <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IPG:  r_ipg  <= i_cfg_data;
                CFG_NG:   r_ng   <= i_cfg_data[NG_W-1:0];
                CFG_LAST: r_last <= i_cfg_data;
                CFG_ITZ:  r_itz  <= i_cfg_data[0];
                default:  ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    logic [CNT_W-1:0] eff_ipg;
    logic [NG_W-1:0]  eff_n;
    logic [CNT_W-1:0] eff_last;
    logic [TOT_W-1:0] bound;

    always_comb begin
        eff_ipg = (r_ipg < MIN_IPG) ? MIN_IPG :
                  (r_ipg > CNT_W'(MAX_IPG)) ? CNT_W'(MAX_IPG) : r_ipg;
        eff_n   = (r_ng == '0) ? NG_W'(1) :
                  (r_ng > NG_W'(MAX_GROUPS)) ? NG_W'(MAX_GROUPS) : r_ng;
        eff_last = (r_last == '0) ? CNT_W'(1) : (r_last > eff_ipg) ? eff_ipg : r_last;
        bound    = TOT_W'(eff_n - NG_W'(1)) * TOT_W'(eff_ipg) + TOT_W'(eff_last);
    end

    // state
    t_state           r_state, n_state;
    logic [BM_AW-1:0] r_clr, n_clr;
    t_op              r_op, n_op;
    logic             r_is_dir, n_is_dir;
    logic [GRP_W-1:0] r_g, n_g;
    logic [WIDX_W-1:0] r_w, n_w;
    logic [IDX_W-1:0] r_i, n_i;
    logic [DIV_W-1:0] r_avg, n_avg;

    logic [CNT_W-1:0] r_gfree [MAX_GROUPS];
    logic [CNT_W-1:0] n_gfree [MAX_GROUPS];
    logic [CNT_W-1:0] r_gdirs [MAX_GROUPS];
    logic [CNT_W-1:0] n_gdirs [MAX_GROUPS];
    logic [CNT_W-1:0] r_gitu  [MAX_GROUPS];
    logic [CNT_W-1:0] n_gitu  [MAX_GROUPS];
    logic [FB_W-1:0]  r_gfb   [MAX_GROUPS];
    logic [FB_W-1:0]  n_gfb   [MAX_GROUPS];
    logic [TOT_W-1:0] r_total, n_total;

    logic             r_res_status, n_res_status;
    logic [INO_W-1:0] r_res_inode, n_res_inode;
    logic [GRP_W-1:0] r_res_grp, n_res_grp;

    logic             r_out_valid, n_out_valid;
    logic             r_out_status, n_out_status;
    logic [INO_W-1:0] r_out_inode, n_out_inode;
    logic [GRP_W-1:0] r_out_grp, n_out_grp;
    logic [TOT_W-1:0] r_out_total, n_out_total;

    // bitmap RAM and divider
    logic              bm_we;
    logic [BM_AW-1:0]  bm_waddr;
    logic [WORD_W-1:0] bm_wdata;
    logic [BM_AW-1:0]  bm_raddr;
    logic [WORD_W-1:0] bm_rdata;
    t_div_req          div_req;
    t_div_rsp          div_rsp;

    iga_ram #(
        .WIDTH (WORD_W),
        .DEPTH (BM_DEPTH)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (bm_we),
        .i_waddr (bm_waddr),
        .i_wdata (bm_wdata),
        .i_raddr (bm_raddr),
        .o_rdata (bm_rdata)
    );

    iga_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // datapath helpers
    logic [CNT_W-1:0]  cur_cnt;
    logic              last_g;
    logic              qualify;
    logic [WORD_W-1:0] masked;
    logic [WORD_W-1:0] lowest;
    logic [BIT_W-1:0]  bsel;
    logic [IDX_W-1:0]  hit_i;
    logic [WIDX_W-1:0] last_w;
    logic [CNT_W-1:0]  cnt_m1;
    logic [CNT_W-1:0]  used;
    logic [GRP_W-1:0]  fq_g;
    logic [CNT_W-1:0]  fq_cnt;
    logic              accept;

    always_comb begin
        cur_cnt = gsize(r_g, eff_n, eff_ipg, eff_last);
        last_g  = (NG_W'(r_g) + NG_W'(1)) == eff_n;
        qualify = (({{(DIV_W-CNT_W){1'b0}}, r_gfree[r_g]} >= r_avg) || last_g)
                  && (r_gfb[r_g] != '0);
        for (int b = 0; b < WORD_W; b++) begin
            masked[b] = bm_rdata[b] | (CNT_W'({r_w, BIT_W'(b)}) >= cur_cnt);
        end
        lowest = ~masked & (masked + WORD_W'(1));
        bsel   = '0;
        for (int b = 0; b < WORD_W; b++) begin
            bsel = bsel | (lowest[b] ? BIT_W'(b) : BIT_W'(0));
        end
        hit_i  = {r_w, bsel};
        cnt_m1 = cur_cnt - CNT_W'(1);
        last_w = cnt_m1[IDX_W-1:BIT_W];
        used   = (r_gitu[r_g] >= cur_cnt) ? '0 : cur_cnt - r_gitu[r_g];
        fq_g   = div_rsp.quot[GRP_W-1:0];
        fq_cnt = gsize(fq_g, eff_n, eff_ipg, eff_last);
        accept = i_valid && o_ready;
    end

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_op         = r_op;
        n_is_dir     = r_is_dir;
        n_g          = r_g;
        n_w          = r_w;
        n_i          = r_i;
        n_avg        = r_avg;
        n_gfree      = r_gfree;
        n_gdirs      = r_gdirs;
        n_gitu       = r_gitu;
        n_gfb        = r_gfb;
        n_total      = r_total;
        n_res_status = r_res_status;
        n_res_inode  = r_res_inode;
        n_res_grp    = r_res_grp;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_status = r_out_status;
        n_out_inode  = r_out_inode;
        n_out_grp    = r_out_grp;
        n_out_total  = r_out_total;

        bm_we    = 1'b0;
        bm_waddr = {r_g, r_i[IDX_W-1:BIT_W]};
        bm_wdata = bm_rdata & ~(WORD_W'(1) << r_i[BIT_W-1:0]);
        bm_raddr = (r_state == S_RD) ? {r_g, r_w} : {r_g, r_i[IDX_W-1:BIT_W]};

        div_req.start    = 1'b0;
        div_req.dividend = r_total;
        div_req.divisor  = DVS_W'(eff_n);

        o_ready = (r_state == S_IDLE);

        unique case (r_state)
            S_CLEAR: begin
                bm_we    = 1'b1;
                bm_waddr = r_clr;
                bm_wdata = '0;
                n_clr    = r_clr + BM_AW'(1);
                if (r_clr == {BM_AW{1'b1}}) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_op         = t_op'(i_op);
                    n_is_dir     = i_is_dir;
                    n_res_status = 1'b0;
                    n_res_inode  = '0;
                    n_res_grp    = '0;
                    unique case (t_op'(i_op))
                        OP_ALLOC: begin
                            div_req.start = 1'b1;
                            n_state       = S_DIV;
                        end
                        OP_FREE: begin
                            if (i_inode_number == '0) begin
                                n_res_status = 1'b1;
                                n_state      = S_FIN;
                            end else begin
                                div_req.start    = 1'b1;
                                div_req.dividend = i_inode_number - INO_W'(1);
                                div_req.divisor  = eff_ipg;
                                n_state          = S_DIV;
                            end
                        end
                        OP_SET_FB: begin
                            n_gfb[i_group_sel] = i_free_blocks;
                            n_res_grp          = i_group_sel;
                            n_state            = S_FIN;
                        end
                        OP_REINIT: begin
                            for (int g = 0; g < MAX_GROUPS; g++) begin
                                n_gfree[g] = (NG_W'(g) < eff_n) ?
                                    gsize(GRP_W'(g), eff_n, eff_ipg, eff_last) : '0;
                                n_gitu[g]  = n_gfree[g];
                                n_gdirs[g] = '0;
                            end
                            n_total = bound;
                            n_state = S_FIN;
                        end
                        default: ;
                    endcase
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    if (r_op == OP_ALLOC) begin
                        n_avg   = div_rsp.quot;
                        n_g     = '0;
                        n_state = S_GRP;
                    end else if (div_rsp.quot >= DIV_W'(eff_n) ||
                                 div_rsp.rem >= fq_cnt) begin
                        n_res_status = 1'b1;
                        n_state      = S_FIN;
                    end else begin
                        n_g     = fq_g;
                        n_i     = div_rsp.rem[IDX_W-1:0];
                        n_state = S_FREE_RD;
                    end
                end
            end
            S_GRP: begin
                if (qualify) begin
                    n_w     = '0;
                    n_state = S_RD;
                end else if (last_g) begin
                    n_res_status = 1'b1;
                    n_state      = S_FIN;
                end else begin
                    n_g = r_g + GRP_W'(1);
                end
            end
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                if (lowest != '0) begin
                    bm_we    = 1'b1;
                    bm_waddr = {r_g, r_w};
                    bm_wdata = bm_rdata | lowest;
                    if (r_gfree[r_g] != '0) begin
                        n_gfree[r_g] = r_gfree[r_g] - CNT_W'(1);
                    end
                    if (r_is_dir && r_gdirs[r_g] < cur_cnt) begin
                        n_gdirs[r_g] = r_gdirs[r_g] + CNT_W'(1);
                    end
                    if (r_itz && CNT_W'(hit_i) >= used) begin
                        n_gitu[r_g] = cur_cnt - CNT_W'(hit_i) - CNT_W'(1);
                    end
                    if (r_total != '0) begin
                        n_total = r_total - TOT_W'(1);
                    end
                    n_res_inode = INO_W'(r_g) * INO_W'(eff_ipg) + INO_W'(hit_i) + INO_W'(1);
                    n_res_grp   = r_g;
                    n_state     = S_FIN;
                end else if (r_w != last_w) begin
                    n_w     = r_w + WIDX_W'(1);
                    n_state = S_RD;
                end else if (last_g) begin
                    n_res_status = 1'b1;
                    n_state      = S_FIN;
                end else begin
                    n_g     = r_g + GRP_W'(1);
                    n_state = S_GRP;
                end
            end
            S_FREE_RD: begin
                n_state = S_FREE_WR;
            end
            S_FREE_WR: begin
                bm_we = 1'b1;
                if (r_is_dir && r_gdirs[r_g] != '0) begin
                    n_gdirs[r_g] = r_gdirs[r_g] - CNT_W'(1);
                end
                if (r_gfree[r_g] < cur_cnt) begin
                    n_gfree[r_g] = r_gfree[r_g] + CNT_W'(1);
                end
                if (r_total < bound) begin
                    n_total = r_total + TOT_W'(1);
                end
                n_res_grp = r_g;
                n_state   = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_inode  = r_res_inode;
                    n_out_grp    = r_res_grp;
                    n_out_total  = r_total;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_total     <= RST_TOTAL;
            for (int g = 0; g < MAX_GROUPS; g++) begin
                r_gfree[g] <= RST_IPG;
                r_gitu[g]  <= RST_IPG;
                r_gdirs[g] <= '0;
                r_gfb[g]   <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            r_total     <= n_total;
            r_gfree     <= n_gfree;
            r_gitu      <= n_gitu;
            r_gdirs     <= n_gdirs;
            r_gfb       <= n_gfb;
        end
        r_op         <= n_op;
        r_is_dir     <= n_is_dir;
        r_g          <= n_g;
        r_w          <= n_w;
        r_i          <= n_i;
        r_avg        <= n_avg;
        r_res_status <= n_res_status;
        r_res_inode  <= n_res_inode;
        r_res_grp    <= n_res_grp;
        r_out_status <= n_out_status;
        r_out_inode  <= n_out_inode;
        r_out_grp    <= n_out_grp;
        r_out_total  <= n_out_total;
    end

    assign o_valid           = r_out_valid;
    assign o_status          = r_out_status;
    assign o_allocated_inode = r_out_inode;
    assign o_alloc_group     = r_out_grp;
    assign o_total_free      = r_out_total;

    `IGA_ASSERT(a_div_done_in_wait, div_rsp.done |-> r_state == S_DIV, "divider result outside wait state")
    `IGA_ASSERT(a_fail_no_inode, o_valid && o_status |-> o_allocated_inode == '0, "failed beat carries an inode")
    `IGA_ASSERT(a_accept_leaves_idle, accept |=> r_state != S_IDLE, "accepted beat left block idle")

endmodule
